[rtl/core/seg_isect_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package seg_isect_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_OUTSIDE  = 2'd2
	} status_t;

endpackage

`default_nettype wire

[rtl/core/segment_intersection.sv]
`timescale 1ns / 1ps
`default_nettype none

// Segment intersection pipeline. Each input beat carries two segments. Each segment is
// given by its two end points as signed fixed-point coordinates. The binary point does
// not enter the arithmetic, so any Q format works. One pair is taken every cycle
// unless the output stalls. The pipeline has 7 stages of exact wide products and
// sums, then one restoring divider stage for each of the COORD_WIDTH + 1 quotient
// bits, then sign fix, range check and the output register.
// Status is hit, parallel or degenerate (zero determinant), or outside. The outside
// status means the truncated point lies outside the x or y range of either segment.
// cross_x and cross_y are zero unless the status is hit.
// A result beat waiting on a low m_tready holds the whole pipeline, and s_tready
// drops with it. While the output is empty, the pipeline advances.
module segment_intersection #(
	parameter int COORD_WIDTH = seg_isect_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
	input  wire logic [8*COORD_WIDTH-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// status, cross_x, cross_y, zero fill
	output logic [((2*COORD_WIDTH+9)/8)*8-1:0] m_tdata
);
	import seg_isect_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int IW   = 8 * W;
	localparam int OW   = ((2 * W + 9) / 8) * 8;
	localparam int DW   = W + 1;
	localparam int PW   = 2 * DW;
	localparam int DETW = 2 * W + 3;
	localparam int CW   = 2 * W + 1;
	localparam int NP   = CW + DW;
	localparam int NW   = 3 * W + 3;
	localparam int QW   = W + 1;

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	function automatic logic signed [W-1:0] crd(input logic [IW-1:0] d, input int k);
		crd = $signed(d[k*W +: W]);
	endfunction

	// stage 1: differences
	logic            v_s1;
	logic [IW-1:0]   c_s1;
	logic signed [DW-1:0] dxa_s1, dya_s1, dxb_s1, dyb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1   <= s_tdata;
			dxa_s1 <= DW'(crd(s_tdata, 0)) - DW'(crd(s_tdata, 2));
			dya_s1 <= DW'(crd(s_tdata, 1)) - DW'(crd(s_tdata, 3));
			dxb_s1 <= DW'(crd(s_tdata, 4)) - DW'(crd(s_tdata, 6));
			dyb_s1 <= DW'(crd(s_tdata, 5)) - DW'(crd(s_tdata, 7));
		end
	end

	// stage 2: first products
	logic            v_s2;
	logic [IW-1:0]   c_s2;
	logic signed [DW-1:0] dxa_s2, dya_s2, dxb_s2, dyb_s2;
	logic signed [PW-1:0] pd1_s2, pd2_s2;
	logic signed [2*W-1:0] pa1_s2, pa2_s2, pb1_s2, pb2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2   <= c_s1;
			dxa_s2 <= dxa_s1;
			dya_s2 <= dya_s1;
			dxb_s2 <= dxb_s1;
			dyb_s2 <= dyb_s1;
			pd1_s2 <= PW'(dxa_s1) * PW'(dyb_s1);
			pd2_s2 <= PW'(dya_s1) * PW'(dxb_s1);
			pa1_s2 <= (2*W)'(crd(c_s1, 0)) * (2*W)'(crd(c_s1, 3));
			pa2_s2 <= (2*W)'(crd(c_s1, 1)) * (2*W)'(crd(c_s1, 2));
			pb1_s2 <= (2*W)'(crd(c_s1, 4)) * (2*W)'(crd(c_s1, 7));
			pb2_s2 <= (2*W)'(crd(c_s1, 5)) * (2*W)'(crd(c_s1, 6));
		end
	end

	// stage 3: determinant and cross terms
	logic            v_s3;
	logic [IW-1:0]   c_s3;
	logic signed [DW-1:0] dxa_s3, dya_s3, dxb_s3, dyb_s3;
	logic signed [DETW-1:0] det_s3;
	logic signed [CW-1:0] ca_s3, cb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3   <= c_s2;
			dxa_s3 <= dxa_s2;
			dya_s3 <= dya_s2;
			dxb_s3 <= dxb_s2;
			dyb_s3 <= dyb_s2;
			det_s3 <= DETW'(pd1_s2) - DETW'(pd2_s2);
			ca_s3  <= CW'(pa1_s2) - CW'(pa2_s2);
			cb_s3  <= CW'(pb1_s2) - CW'(pb2_s2);
		end
	end

	// stage 4: numerator products
	logic            v_s4;
	logic [IW-1:0]   c_s4;
	logic signed [DETW-1:0] det_s4;
	logic signed [NP-1:0] m1_s4, m2_s4, m3_s4, m4_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4   <= c_s3;
			det_s4 <= det_s3;
			m1_s4  <= NP'(ca_s3) * NP'(dxb_s3);
			m2_s4  <= NP'(dxa_s3) * NP'(cb_s3);
			m3_s4  <= NP'(ca_s3) * NP'(dyb_s3);
			m4_s4  <= NP'(dya_s3) * NP'(cb_s3);
		end
	end

	// stage 5: numerators
	logic            v_s5, dz_s5;
	logic [IW-1:0]   c_s5;
	logic signed [DETW-1:0] det_s5;
	logic signed [NW-1:0] nx_s5, ny_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s5   <= c_s4;
			det_s5 <= det_s4;
			dz_s5  <= det_s4 == '0;
			nx_s5  <= NW'(m1_s4) - NW'(m2_s4);
			ny_s5  <= NW'(m3_s4) - NW'(m4_s4);
		end
	end

	// stage 6: magnitudes and quotient signs
	logic            v_s6, dz_s6, sx_s6, sy_s6;
	logic [IW-1:0]   c_s6;
	logic [DETW-1:0] ad_s6;
	logic [NW-1:0]   ax_s6, ay_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6  <= c_s5;
			dz_s6 <= dz_s5;
			sx_s6 <= nx_s5[NW-1] ^ det_s5[DETW-1];
			sy_s6 <= ny_s5[NW-1] ^ det_s5[DETW-1];
			ad_s6 <= det_s5[DETW-1] ? DETW'(-det_s5) : DETW'(det_s5);
			ax_s6 <= nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
			ay_s6 <= ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
		end
	end

	// divider chain; index 0 is stage 7, index k+1 holds quotient bits down to W-k
	logic            dv_q  [0:QW];
	logic            ddz_q [0:QW];
	logic            dsx_q [0:QW];
	logic            dsy_q [0:QW];
	logic            dox_q [0:QW];
	logic            doy_q [0:QW];
	logic [IW-1:0]   dc_q  [0:QW];
	logic [DETW-1:0] dd_q  [0:QW];
	logic [NW-1:0]   drx_q [0:QW];
	logic [NW-1:0]   dry_q [0:QW];
	logic [QW-1:0]   dqx_q [0:QW];
	logic [QW-1:0]   dqy_q [0:QW];

	logic [NW:0] lim_s7;
	assign lim_s7 = {ad_s6, {QW{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q[0] <= 1'b0;
		end else if (en) begin
			dv_q[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ddz_q[0] <= dz_s6;
			dsx_q[0] <= sx_s6;
			dsy_q[0] <= sy_s6;
			dox_q[0] <= {1'b0, ax_s6} >= lim_s7;
			doy_q[0] <= {1'b0, ay_s6} >= lim_s7;
			dc_q[0]  <= c_s6;
			dd_q[0]  <= ad_s6;
			drx_q[0] <= ax_s6;
			dry_q[0] <= ay_s6;
			dqx_q[0] <= '0;
			dqy_q[0] <= '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [NW-1:0] ds;
		logic          bx, by;
		assign ds = NW'({{(NW-DETW){1'b0}}, dd_q[k]} << (W - k));
		assign bx = drx_q[k] >= ds;
		assign by = dry_q[k] >= ds;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_q[k+1] <= 1'b0;
			end else if (en) begin
				dv_q[k+1] <= dv_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ddz_q[k+1] <= ddz_q[k];
				dsx_q[k+1] <= dsx_q[k];
				dsy_q[k+1] <= dsy_q[k];
				dox_q[k+1] <= dox_q[k];
				doy_q[k+1] <= doy_q[k];
				dc_q[k+1]  <= dc_q[k];
				dd_q[k+1]  <= dd_q[k];
				drx_q[k+1] <= bx ? drx_q[k] - ds : drx_q[k];
				dry_q[k+1] <= by ? dry_q[k] - ds : dry_q[k];
				dqx_q[k+1] <= {dqx_q[k][QW-2:0], bx};
				dqy_q[k+1] <= {dqy_q[k][QW-2:0], by};
			end
		end
	end

	// stage 8: apply sign
	logic            v_s8, dz_s8, ov_s8;
	logic [IW-1:0]   c_s8;
	logic signed [QW:0] px_s8, py_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= dv_q[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8  <= dc_q[QW];
			dz_s8 <= ddz_q[QW];
			ov_s8 <= dox_q[QW] || doy_q[QW];
			px_s8 <= dsx_q[QW] ? -$signed({1'b0, dqx_q[QW]}) : $signed({1'b0, dqx_q[QW]});
			py_s8 <= dsy_q[QW] ? -$signed({1'b0, dqy_q[QW]}) : $signed({1'b0, dqy_q[QW]});
		end
	end

	// stage 9: range check
	function automatic logic outside(input logic signed [QW:0] v,
		input logic signed [W-1:0] p, input logic signed [W-1:0] q);
		logic signed [QW:0] pe, qe;
		pe = (QW+1)'(p);
		qe = (QW+1)'(q);
		outside = (v < pe && v < qe) || (v > pe && v > qe);
	endfunction

	logic            v_s9;
	status_t         st_s9;
	logic [W-1:0]    x_s9, y_s9;
	logic            out_s8;

	assign out_s8 = ov_s8 || outside(px_s8, crd(c_s8, 0), crd(c_s8, 2))
		|| outside(px_s8, crd(c_s8, 4), crd(c_s8, 6))
		|| outside(py_s8, crd(c_s8, 1), crd(c_s8, 3))
		|| outside(py_s8, crd(c_s8, 5), crd(c_s8, 7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_s8) begin
				st_s9 <= ST_PARALLEL;
				x_s9  <= '0;
				y_s9  <= '0;
			end else if (out_s8) begin
				st_s9 <= ST_OUTSIDE;
				x_s9  <= '0;
				y_s9  <= '0;
			end else begin
				st_s9 <= ST_HIT;
				x_s9  <= px_s8[W-1:0];
				y_s9  <= py_s8[W-1:0];
			end
		end
	end

	// output register
	logic [OW-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= OW'({y_s9, x_s9, st_s9});
		end
	end

	assign m_tdata = data_q;

endmodule

`default_nettype wire
